>>> rtl/adfs_pkg.sv
// adfs_pkg: shared types and constants for the depth-first order block
// controller/datapath command and status structs, field widths, command codes
// no dependencies
package adfs_pkg;

  localparam int VERTEX_W    = 6;
  localparam int ROW_W       = 64;
  localparam int COUNT_W     = 7;
  localparam int COUNT_RESET = 64;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic load_row;
    logic run_init;
    logic bad_init;
    logic pop_read;
    logic visit;
    logic push_step;
    logic emit_last;
  } adfs_cmd_t;

  typedef struct packed {
    logic item_run;
    logic start_bad;
    logic stack_empty;
    logic popped_visited;
    logic pending_valid;
    logic out_free;
    logic scan_zero;
  } adfs_stat_t;

endpackage

>>> rtl/adfs_ram.sv
// adfs_ram: generic single-write, single-read memory with registered read
// no dependencies
module adfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/adfs_ctrl.sv
// adfs_ctrl: sequencer for loads and depth-first runs
// depends on adfs_pkg
module adfs_ctrl
  import adfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  adfs_stat_t stat,
  output adfs_cmd_t  ctl
);

  typedef enum logic [2:0] {
    IDLE,
    POP_RD,
    POP_CHK,
    SCAN,
    DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          if (!stat.item_run) begin
            ctl.load_row = 1'b1;
          end else if (stat.start_bad) begin
            ctl.bad_init = 1'b1;
            state_next   = DONE;
          end else begin
            ctl.run_init = 1'b1;
            state_next   = POP_RD;
          end
        end
      end
      POP_RD: begin
        if (stat.stack_empty) begin
          state_next = DONE;
        end else begin
          ctl.pop_read = 1'b1;
          state_next   = POP_CHK;
        end
      end
      POP_CHK: begin
        if (stat.popped_visited) begin
          state_next = POP_RD;
        end else if (!stat.pending_valid || stat.out_free) begin
          ctl.visit  = 1'b1;
          state_next = SCAN;
        end
      end
      SCAN: begin
        ctl.push_step = 1'b1;
        if (stat.scan_zero) begin
          state_next = POP_RD;
        end
      end
      DONE: begin
        if (stat.out_free) begin
          ctl.emit_last = 1'b1;
          state_next    = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/adfs_datapath.sv
// adfs_datapath: adjacency memory, pending stack, visited map, neighbor scan, result register
// depends on adfs_pkg and adfs_ram
module adfs_datapath
  import adfs_pkg::*;
#(
  parameter int MAX_NODES   = 64,
  parameter int STACK_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  adfs_cmd_t           ctl,
  output adfs_stat_t          stat,
  input  logic                cfg_write,
  input  logic [COUNT_W-1:0]  cfg_data,
  input  logic                cmd,
  input  logic [VERTEX_W-1:0] row_index,
  input  logic [ROW_W-1:0]    row_bits,
  input  logic [VERTEX_W-1:0] start_vertex,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VERTEX_W-1:0] vertex,
  output logic                last,
  output logic                bad_start
);

  localparam int VW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);

  logic [COUNT_W-1:0]   vertex_count;
  logic [CW-1:0]        cnt;
  logic [MAX_NODES-1:0] visited;
  logic [FW-1:0]        stack_fill;
  logic [VW-1:0]        scan_idx;
  logic [VW-1:0]        pend_vertex;
  logic                 pend_bad;
  logic                 pending_valid;

  logic                 row_we;
  logic [MAX_NODES-1:0] row_rdata;
  logic                 stk_we;
  logic [AW-1:0]        stk_waddr;
  logic [VW-1:0]        stk_wdata;
  logic [AW-1:0]        stk_raddr;
  logic [VW-1:0]        stk_rdata;
  logic                 stack_full;
  logic                 push_hit;
  logic                 out_free;

  assign cnt = (vertex_count > COUNT_W'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(vertex_count);

  assign stack_full = (stack_fill == FW'(STACK_DEPTH));
  assign push_hit   = row_rdata[scan_idx] & ~visited[scan_idx] & ~stack_full;
  assign out_free   = !out_valid || out_ready;

  assign row_we = ctl.load_row && (COUNT_W'(row_index) < COUNT_W'(cnt));

  // start vertex goes to the bottom slot, neighbors to the slot above the current top
  assign stk_we    = ctl.run_init || (ctl.push_step && push_hit);
  assign stk_waddr = ctl.run_init ? '0 : AW'(stack_fill);
  assign stk_wdata = ctl.run_init ? start_vertex[VW-1:0] : scan_idx;
  assign stk_raddr = AW'(stack_fill - FW'(1));

  adfs_ram #(
    .WIDTH(MAX_NODES),
    .DEPTH(MAX_NODES)
  ) u_rows (
    .clk  (clk),
    .we   (row_we),
    .waddr(row_index[VW-1:0]),
    .wdata(row_bits[MAX_NODES-1:0]),
    .re   (ctl.visit),
    .raddr(stk_rdata),
    .rdata(row_rdata)
  );

  adfs_ram #(
    .WIDTH(VW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (ctl.pop_read),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  always_comb begin
    stat                = '0;
    stat.item_run       = (cmd == CMD_RUN);
    stat.start_bad      = (COUNT_W'(start_vertex) >= COUNT_W'(cnt));
    stat.stack_empty    = (stack_fill == '0);
    stat.popped_visited = visited[stk_rdata];
    stat.pending_valid  = pending_valid;
    stat.out_free       = out_free;
    stat.scan_zero      = (scan_idx == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= COUNT_W'(COUNT_RESET);
      visited       <= '0;
      stack_fill    <= '0;
      pending_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      if (ctl.run_init) begin
        visited    <= '0;
        stack_fill <= FW'(1);
      end
      if (ctl.bad_init || ctl.run_init) begin
        pending_valid <= ctl.bad_init;
      end
      if (ctl.pop_read) begin
        stack_fill <= stack_fill - FW'(1);
      end
      if (ctl.visit) begin
        visited[stk_rdata] <= 1'b1;
        pending_valid      <= 1'b1;
      end
      if (ctl.push_step && push_hit) begin
        stack_fill <= stack_fill + FW'(1);
      end
      if ((ctl.visit && pending_valid) || ctl.emit_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.emit_last) begin
        pending_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.bad_init) begin
      pend_vertex <= '0;
      pend_bad    <= 1'b1;
    end
    if (ctl.visit) begin
      pend_vertex <= stk_rdata;
      pend_bad    <= 1'b0;
      scan_idx    <= VW'(cnt - CW'(1));
    end
    if (ctl.push_step) begin
      scan_idx <= scan_idx - VW'(1);
    end
    if ((ctl.visit && pending_valid) || ctl.emit_last) begin
      vertex    <= VERTEX_W'(pend_vertex);
      last      <= ctl.emit_last;
      bad_start <= pend_bad;
    end
  end

endmodule

>>> rtl/adjacency_matrix_dfs_order.sv
// adjacency_matrix_dfs_order: top level, controller plus datapath
// depends on adfs_pkg, adfs_ctrl, adfs_datapath
//
// Loads adjacency rows one beat at a time (cmd load) and, on a run beat, emits the
// depth-first visit order from start_vertex, lowest-numbered neighbor first, with
// last set on the final vertex; a start at or above vertex_count (capped at MAX_NODES)
// gives one beat with bad_start and last set and vertex 0. During a run the neighbor
// scan checks one column of the row per cycle and pushes at most one entry per cycle
// through the single write port of the stack memory. No new beat is taken until the
// run's last result is in the output register. vertex_count is written on the cfg
// channel; the user must do so only while the block is idle, which the block itself
// does not enforce.
module adjacency_matrix_dfs_order
  import adfs_pkg::*;
#(
  parameter int MAX_NODES   = 64,
  parameter int STACK_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [VERTEX_W-1:0] row_index,
  input  logic [ROW_W-1:0]    row_bits,
  input  logic [VERTEX_W-1:0] start_vertex,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VERTEX_W-1:0] vertex,
  output logic                last,
  output logic                bad_start
);

  adfs_cmd_t  ctl;
  adfs_stat_t stat;

  assign cfg_ready = 1'b1;

  adfs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .ctl     (ctl)
  );

  adfs_datapath #(
    .MAX_NODES  (MAX_NODES),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .row_index   (row_index),
    .row_bits    (row_bits),
    .start_vertex(start_vertex),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vertex      (vertex),
    .last        (last),
    .bad_start   (bad_start)
  );

  // a flagged start is always a lone final beat at vertex 0
  a_bad_start_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_start |-> last && (vertex == '0))
    else $error("bad_start beat without last or with nonzero vertex");

  // no result is left pending once the block is idle
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.pending_valid)
    else $error("pending result held while idle");

  // a run beat always takes the block busy
  a_run_goes_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_RUN) |=> !in_ready)
    else $error("input taken again right after a run beat");

endmodule
